// File: hdl/spcb_pkg.sv
// shared constants and exp table for the softmax palette blend
`default_nettype none
package spcb_pkg;

  localparam int unsigned WeightW  = 16;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned ExpW     = 17;
  localparam int unsigned AccW     = 25;
  localparam int unsigned DiffBits = 15;
  localparam int unsigned SumW     = 21;
  localparam int unsigned ChanSumW = 28;
  localparam logic [AccW-1:0] ExpOneQ24 = 25'd16777216;
  localparam logic [SumW-1:0] SumLimit  = 21'd1310720;

  localparam logic [2:0] RegTypes = 3'd0;
  localparam logic [2:0] RegPal0  = 3'd1;
  localparam logic [2:0] RegPal1  = 3'd2;
  localparam logic [2:0] RegPal2  = 3'd3;
  localparam logic [2:0] RegPal3  = 3'd4;

  function automatic logic [23:0] exp_bit(input logic [3:0] k);
    logic [23:0] c;
    unique case (k)
      4'd0:    c = 24'd16766979;
      4'd1:    c = 24'd16756748;
      4'd2:    c = 24'd16736306;
      4'd3:    c = 24'd16695496;
      4'd4:    c = 24'd16614173;
      4'd5:    c = 24'd16452715;
      4'd6:    c = 24'd16134491;
      4'd7:    c = 24'd15516388;
      4'd8:    c = 24'd14350313;
      4'd9:    c = 24'd12274473;
      4'd10:   c = 24'd8980197;
      4'd11:   c = 24'd4806753;
      4'd12:   c = 24'd1377158;
      4'd13:   c = 24'd113044;
      4'd14:   c = 24'd762;
      default: c = 24'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hdl/spcb_exp_cell.sv
// one step of the exp chain: optional multiply by one table constant, then register
`default_nettype none
module spcb_exp_cell #(
  parameter int unsigned K     = 0,
  parameter int unsigned Lanes = 8
) (
  input  wire                                    clk_i,
  input  wire  [Lanes-1:0][spcb_pkg::AccW-1:0]    acc_i,
  input  wire  [Lanes-1:0][spcb_pkg::DiffBits-1:0] diff_i,
  output logic [Lanes-1:0][spcb_pkg::AccW-1:0]    acc_o,
  output logic [Lanes-1:0][spcb_pkg::DiffBits-1:0] diff_o
);
  localparam logic [23:0] C = spcb_pkg::exp_bit(K[3:0]);
  logic [Lanes-1:0][spcb_pkg::AccW-1:0] acc_d;
  logic [48:0] prod [Lanes];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      prod[l] = 49'(acc_i[l]) * 49'(C) + 49'(24'h800000);
      acc_d[l] = diff_i[l][K] ? prod[l][48:24] : acc_i[l];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_o  <= acc_d;
    diff_o <= diff_i;
  end
endmodule
`default_nettype wire

// File: hdl/spcb_div_cell.sv
// one restoring-division cell: resolves one quotient bit for three channels
`default_nettype none
module spcb_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  wire                               clk_i,
  input  wire  [2:0][spcb_pkg::ChanSumW-1:0] rem_i,
  input  wire  [2:0][7:0]                   quo_i,
  input  wire  [spcb_pkg::SumW-1:0]         den_i,
  output logic [2:0][spcb_pkg::ChanSumW-1:0] rem_o,
  output logic [2:0][7:0]                   quo_o,
  output logic [spcb_pkg::SumW-1:0]         den_o
);
  logic [2:0][spcb_pkg::ChanSumW-1:0] rem_d;
  logic [2:0][7:0] quo_d;
  logic [spcb_pkg::ChanSumW+7:0] sh;

  always_comb begin
    sh = ({8'd0, spcb_pkg::ChanSumW'(den_i)}) << Bit;
    for (int c = 0; c < 3; c++) begin
      rem_d[c] = rem_i[c];
      quo_d[c] = quo_i[c];
      if ({8'd0, rem_i[c]} >= sh) begin
        rem_d[c]      = rem_i[c] - sh[spcb_pkg::ChanSumW-1:0];
        quo_d[c][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o <= rem_d;
    quo_o <= quo_d;
    den_o <= den_i;
  end
endmodule
`default_nettype wire

// File: hdl/softmax_palette_color_blend_core.sv
// top level of the softmax palette color blend
`default_nettype none
// Pipelined softmax-weighted palette blend. One pixel (start_i while busy_o is
// low) is accepted every cycle; busy_o is always low. Each pixel's result is
// shown for one cycle with valid_o once it has passed the 27 register stages;
// the receiver cannot stall it. The pipe is a row of cells: one max/diff stage,
// fifteen exp cells (one table constant per cell, eight lanes), one round/sum
// stage, one multiply stage, eight division cells (one quotient bit each) and
// the output register. Configuration is sampled at acceptance and must only
// change idle.
module softmax_palette_color_blend_core #(
  parameter int unsigned MAX_TYPES = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [5:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [15:0] weight_0_i,
  input  wire  [15:0] weight_1_i,
  input  wire  [15:0] weight_2_i,
  input  wire  [15:0] weight_3_i,
  input  wire  [15:0] weight_4_i,
  input  wire  [15:0] weight_5_i,
  input  wire  [15:0] weight_6_i,
  input  wire  [15:0] weight_7_i,
  output logic        valid_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        blended_o,
  output logic [2:0]  winner_o
);
  localparam int unsigned L = MAX_TYPES;
  localparam int unsigned NExp = spcb_pkg::DiffBits;
  localparam int unsigned Lat = NExp + 8 + 3;

  typedef struct packed {
    logic       pos;
    logic [2:0] win;
    logic [L-1:0] use_m;
  } ctl_t;

  // configuration registers
  logic [3:0]  types_q;
  logic [3:0][47:0] pal_q;
  logic [2:0]  ridx;
  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign ridx   = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      types_q <= 4'd8;
      pal_q   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        spcb_pkg::RegTypes: types_q  <= pwdata[3:0];
        spcb_pkg::RegPal0:  pal_q[0] <= pwdata[47:0];
        spcb_pkg::RegPal1:  pal_q[1] <= pwdata[47:0];
        spcb_pkg::RegPal2:  pal_q[2] <= pwdata[47:0];
        spcb_pkg::RegPal3:  pal_q[3] <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      spcb_pkg::RegTypes: prdata = {60'd0, types_q};
      spcb_pkg::RegPal0:  prdata = {16'd0, pal_q[0]};
      spcb_pkg::RegPal1:  prdata = {16'd0, pal_q[1]};
      spcb_pkg::RegPal2:  prdata = {16'd0, pal_q[2]};
      spcb_pkg::RegPal3:  prdata = {16'd0, pal_q[3]};
      default:            prdata = '0;
    endcase
  end

  // stage 0: max search with lowest-index ties, differences to the max
  logic signed [15:0] w [8];
  assign w[0] = weight_0_i; assign w[1] = weight_1_i;
  assign w[2] = weight_2_i; assign w[3] = weight_3_i;
  assign w[4] = weight_4_i; assign w[5] = weight_5_i;
  assign w[6] = weight_6_i; assign w[7] = weight_7_i;

  logic [3:0] n;
  logic signed [15:0] mx;
  logic [2:0] best;
  logic [L-1:0][spcb_pkg::DiffBits-1:0] diff0;
  logic [L-1:0][spcb_pkg::AccW-1:0] one0;
  ctl_t ctl0;
  logic [16:0] dd;

  always_comb begin
    n = types_q;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(L)) n = 4'(L);
    mx = w[0];
    best = 3'd0;
    for (int i = 1; i < L; i++) begin
      if (4'(i) < n && w[i] > mx) begin
        mx = w[i];
        best = 3'(i);
      end
    end
    ctl0.pos = mx > 16'sd0;
    ctl0.win = best;
    for (int i = 0; i < L; i++) begin
      dd = 17'(signed'(mx)) - 17'(signed'(w[i]));
      diff0[i] = dd[14:0];
      ctl0.use_m[i] = (4'(i) < n) && (w[i] > 16'sd0);
      one0[i] = spcb_pkg::ExpOneQ24;
    end
  end

  logic [L-1:0][spcb_pkg::AccW-1:0] acc_s [NExp+1];
  logic [L-1:0][spcb_pkg::DiffBits-1:0] dif_s [NExp+1];
  ctl_t ctl_p [Lat];
  logic [Lat-1:0] vld_q;
  logic [4*48-1:0] pal_p [Lat];

  always_ff @(posedge clk_i) begin
    acc_s[0] <= one0;
    dif_s[0] <= diff0;
    ctl_p[0] <= ctl0;
    pal_p[0] <= pal_q;
    for (int s = 1; s < Lat; s++) begin
      ctl_p[s] <= ctl_p[s-1];
      pal_p[s] <= pal_p[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[Lat-2:0], start_i};
  end

  // exp chain: cell k folds in the constant for bit k of the difference
  for (genvar k = 0; k < NExp; k++) begin : g_exp
    spcb_exp_cell #(.K(k), .Lanes(L)) u_cell (
      .clk_i (clk_i),
      .acc_i (acc_s[k]),
      .diff_i(dif_s[k]),
      .acc_o (acc_s[k+1]),
      .diff_o(dif_s[k+1])
    );
  end
  // acc_s[NExp] aligns with ctl_p[NExp]

  // round to q1.16, mask unused lanes and lanes with non-positive weight, sum
  logic [L-1:0][spcb_pkg::ExpW-1:0] e_d, e_q;
  logic [spcb_pkg::SumW-1:0] sum_d, sum_q;
  logic [spcb_pkg::AccW:0] rnd;
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < L; i++) begin
      rnd = {1'b0, acc_s[NExp][i]} + 26'd128;
      e_d[i] = ctl_p[NExp].use_m[i] ? rnd[24:8] : '0;
      sum_d = sum_d + spcb_pkg::SumW'(e_d[i]);
    end
  end
  always_ff @(posedge clk_i) begin
    e_q <= e_d;
    sum_q <= sum_d;
  end

  // weighted color sums plus half the divisor
  localparam int unsigned SM = NExp + 1;
  logic [2:0][spcb_pkg::ChanSumW-1:0] csum_d;
  logic [2:0][7:0] ch;
  logic [23:0] col;
  always_comb begin
    csum_d = '0;
    for (int i = 0; i < L; i++) begin
      col = pal_p[SM][24*i +: 24];
      for (int c = 0; c < 3; c++) begin
        ch[c] = col[8*c +: 8];
        csum_d[c] = csum_d[c] + spcb_pkg::ChanSumW'(ch[c]) * spcb_pkg::ChanSumW'(e_q[i]);
      end
    end
    for (int c = 0; c < 3; c++)
      csum_d[c] = csum_d[c] + spcb_pkg::ChanSumW'(sum_q >> 1);
  end

  logic [2:0][spcb_pkg::ChanSumW-1:0] rem_s [9];
  logic [2:0][7:0] quo_s [9];
  logic [spcb_pkg::SumW-1:0] den_s [9];
  always_ff @(posedge clk_i) begin
    rem_s[0] <= csum_d;
    quo_s[0] <= '0;
    den_s[0] <= sum_q;
  end

  // division row, msb first; quotient fits eight bits
  for (genvar b = 0; b < 8; b++) begin : g_div
    spcb_div_cell #(.Bit(7 - b)) u_div (
      .clk_i(clk_i),
      .rem_i(rem_s[b]), .quo_i(quo_s[b]), .den_i(den_s[b]),
      .rem_o(rem_s[b+1]), .quo_o(quo_s[b+1]), .den_o(den_s[b+1])
    );
  end

  // output register: pick blend or winner color
  localparam int unsigned SO = Lat - 1;
  logic blend_ok;
  logic [23:0] wcol;
  assign blend_ok = ctl_p[SO].pos && den_s[8] != '0 && den_s[8] <= spcb_pkg::SumLimit;
  assign wcol = pal_p[SO][24*ctl_p[SO].win +: 24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= vld_q[Lat-1];
  end
  always_ff @(posedge clk_i) begin
    winner_o  <= ctl_p[SO].win;
    blended_o <= blend_ok;
    red_o     <= blend_ok ? quo_s[8][0] : wcol[7:0];
    green_o   <= blend_ok ? quo_s[8][1] : wcol[15:8];
    blue_o    <= blend_ok ? quo_s[8][2] : wcol[23:16];
  end
endmodule
`default_nettype wire
